FILE: src/iss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg: shared types for the insertion sort chain
// Record, cell view and per-cycle control structures, plus the control states.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int KEY_W = 17;
  localparam int TAG_W = 10;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;

  // One stored record and its occupancy bit
  typedef struct packed {
    logic valid;
    key_t key;
    tag_t tag;
  } cell_rec_t;

  // What a cell shows its neighbors: its record and whether it sorts after
  // the word being inserted
  typedef struct packed {
    cell_rec_t rec;
    logic      gt;
  } cell_view_t;

  // Broadcast to every cell in a cycle
  typedef struct packed {
    logic ins;
    logic shift;
    key_t key;
    tag_t tag;
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

FILE: src/insertion_sort_by_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_by_key: stable ascending sort of keyed records
// Systolic chain of MAX_RECORDS cells that keeps the loaded set in key order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one record word per handshake,
//   sort_key, record_tag and last_record. While loading, in_stall is low and
//   a word is taken every cycle: every cell compares against the new key at
//   once and either keeps, shifts right or captures the new record.
//   A word carrying last_record closes the set. The next cycle the block
//   starts draining: out_valid rises with the smallest record in the head
//   cell, and each taken word shifts the whole chain left by one cell.
//   in_stall stays high for the whole drain, and goes low again in the cycle
//   after the word flagged out_last is taken.
//   Receiver stall: out_stall freezes the chain, so the presented word holds.
//   Overflow: once all cells are full, further records are dropped and the
//   overflow output is high on every word of that set's drain.
//   Reset (rst, synchronous): empty every cell, clear the overflow flag and
//   return to loading. No clearing pass is needed.
// ----------------------------------------------------------------------------
module insertion_sort_by_key #(
  parameter int MAX_RECORDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  iss_pkg::key_t      sort_key,
  input  iss_pkg::tag_t      record_tag,
  input  logic               last_record,
  output logic               out_valid,
  input  logic               out_stall,
  output iss_pkg::key_t      out_key,
  output iss_pkg::tag_t      out_tag,
  output logic               out_last,
  output logic               overflow
);
  import iss_pkg::*;

  // Left of the head acts as an occupied slot that never sorts after the word
  localparam cell_view_t HEAD_VIEW = '{rec: '{valid: 1'b1, key: '0, tag: '0}, gt: 1'b0};
  // Right of the tail is empty, so draining empties the chain
  localparam cell_rec_t  TAIL_REC  = '{valid: 1'b0, key: '0, tag: '0};

  state_t     state;
  state_t     state_next;
  logic       dropped;
  logic       dropped_next;
  logic       in_take;
  logic       out_take;
  logic       full;
  cell_ctl_t  ctl;
  cell_view_t view [MAX_RECORDS];

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign full     = view[MAX_RECORDS-1].rec.valid;

  // Drop the word when every cell is taken
  assign ctl.ins   = in_take && !full;
  assign ctl.shift = out_take;
  assign ctl.key   = sort_key;
  assign ctl.tag   = record_tag;

  genvar i;
  generate
    for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
      cell_view_t left_v;
      cell_rec_t  right_r;
      if (i == 0) begin : g_head
        assign left_v = HEAD_VIEW;
      end else begin : g_mid_l
        assign left_v = view[i-1];
      end
      if (i == MAX_RECORDS - 1) begin : g_tail
        assign right_r = TAIL_REC;
      end else begin : g_mid_r
        assign right_r = view[i+1].rec;
      end
      iss_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .left  (left_v),
        .right (right_r),
        .view  (view[i])
      );
    end
  endgenerate

  // Head cell drives the result key and tag directly; out_last shows the next cell is empty
  assign out_key  = view[0].rec.key;
  assign out_tag  = view[0].rec.tag;
  assign out_last = !view[1].rec.valid;
  assign overflow = dropped;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next   = state;
    dropped_next = dropped;
    in_stall     = 1'b0;
    out_valid    = 1'b0;
    case (state)
      ST_LOAD: begin
        if (in_take && full) begin
          dropped_next = 1'b1;
        end
        if (in_take && last_record) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
        if (out_take && out_last) begin
          state_next   = ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

FILE: src/iss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_cell: one slot of the insertion sort chain
// Hold one record; on insert keep it, take the new word or the left neighbor's record,
// on drain take the right neighbor's record.
// ----------------------------------------------------------------------------
module iss_cell (
  input  logic              clk,
  input  logic              rst,
  input  iss_pkg::cell_ctl_t  ctl,
  input  iss_pkg::cell_view_t left,
  input  iss_pkg::cell_rec_t  right,
  output iss_pkg::cell_view_t view
);
  import iss_pkg::*;

  cell_rec_t rec;
  cell_rec_t rec_next;
  logic      gt;

  // Equal keys are not greater: the new word lands after them (stable)
  assign gt   = rec.valid && (rec.key > ctl.key);
  assign view = '{rec: rec, gt: gt};

  always_comb begin
    rec_next = rec;
    if (ctl.shift) begin
      rec_next = right;
    end else if (ctl.ins) begin
      if (!rec.valid || gt) begin
        if (left.gt) begin
          rec_next = left.rec;
        end else if (rec.valid || left.rec.valid) begin
          rec_next = '{valid: 1'b1, key: ctl.key, tag: ctl.tag};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.valid <= 1'b0;
    end else begin
      rec.valid <= rec_next.valid;
    end
    rec.key <= rec_next.key;
    rec.tag <= rec_next.tag;
  end

endmodule

FILE: src/iss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_checker: port-level checks for insertion_sort_by_key
// Watch drain ordering, set framing and the output handshake.
// ----------------------------------------------------------------------------
module iss_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          last_record,
  input logic          out_valid,
  input logic          out_stall,
  input iss_pkg::key_t out_key,
  input iss_pkg::tag_t out_tag,
  input logic          out_last
);
  import iss_pkg::*;

  // Input is held off exactly while a sorted set drains
  a_stall_while_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid == in_stall)
    else $error("in_stall does not track drain");

  // Closing a set starts the drain next cycle
  a_last_starts_drain: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && last_record) |=> out_valid)
    else $error("drain did not follow last record");

  // Keys leave in ascending order within a set
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_last) |=> (out_valid && out_key >= $past(out_key)))
    else $error("drain out of key order");

  // Taking the final word ends the drain
  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("drain continued past final word");

  // A stalled result word holds
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_key) && $stable(out_tag)
                                  && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind insertion_sort_by_key iss_checker u_iss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .last_record (last_record),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_key     (out_key),
  .out_tag     (out_tag),
  .out_last    (out_last)
);
